// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/hsl_pkg.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter package
// Fixed field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int SPEED_BITS    = 16;
   localparam int TICK_BITS     = 16;
   localparam int RELOAD_BITS   = 20;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int PROD_BITS     = SPEED_BITS + TICK_BITS;
   localparam int Q_FRAC_BITS   = 16;

   // 10 degrees per second in binary angle units
   localparam logic [SPEED_BITS-1:0] SLEW_SPEED_RESET = 16'd1820;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_SLEW_SPEED       = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_REVERSAL_HOLDOFF = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ONLY_WHEN_MOVING = 2'd2;

   // turn direction, two's complement
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   typedef struct packed {
      logic [SPEED_BITS-1:0]  slew_speed;
      logic [RELOAD_BITS-1:0] reversal_holdoff;
      logic                   only_when_moving;
   } cfg_type;

   typedef struct packed {
      logic present;
      logic moving;
      logic manual;
   } qual_type;

endpackage

// ----- hw/rtl/hsl_req_if.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter request channel
// One tick: target and current heading, tick length and qualifier flags.
// ----------------------------------------------------------------------------
interface hsl_req_if #(
   parameter int ANGLE_BITS = 16
);
   import hsl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ANGLE_BITS-1:0]  target_heading;
   logic [ANGLE_BITS-1:0]  current_heading;
   logic [TICK_BITS-1:0]   tick_length;
   logic                   target_present;
   logic                   target_moving;
   logic                   manual_override;

   modport source (
      output valid, target_heading, current_heading, tick_length,
             target_present, target_moving, manual_override,
      input  ready
   );

   modport sink (
      input  valid, target_heading, current_heading, tick_length,
             target_present, target_moving, manual_override,
      output ready
   );
endinterface

// ----- hw/rtl/hsl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter response channel
// One result per tick: signed heading step and applied flag.
// ----------------------------------------------------------------------------
interface hsl_rsp_if #(
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] heading_step;
   logic                         step_applied;

   modport source (
      output valid, heading_step, step_applied,
      input  ready
   );

   modport sink (
      input  valid, heading_step, step_applied,
      output ready
   );
endinterface

// ----- hw/rtl/hsl_csr_if.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter register write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsl_csr_if;
   import hsl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ----- hw/rtl/hsl_step_core.sv -----
// ----------------------------------------------------------------------------
// Heading slew step core
// Combinational step for one tick: wrap, direction, hold-off, clamp, next state.
// ----------------------------------------------------------------------------
module hsl_step_core #(
   parameter int ANGLE_BITS   = 16,
   parameter int HOLDOFF_BITS = 20
) (
   input  hsl_pkg::cfg_type              cfg,
   input  hsl_pkg::qual_type             qual,
   input  logic [ANGLE_BITS-1:0]         target_heading,
   input  logic [ANGLE_BITS-1:0]         current_heading,
   input  logic [hsl_pkg::TICK_BITS-1:0] tick_length,
   input  logic [1:0]                    last_dir,
   input  logic [HOLDOFF_BITS-1:0]       holdoff_left,
   output logic signed [ANGLE_BITS-1:0]  heading_step,
   output logic                          step_applied,
   output logic [1:0]                    last_dir_next,
   output logic [HOLDOFF_BITS-1:0]       holdoff_next
);
   import hsl_pkg::*;

   localparam int CMP_BITS = (ANGLE_BITS > SPEED_BITS) ? ANGLE_BITS : SPEED_BITS;

   logic [HOLDOFF_BITS-1:0] tick_ext;
   logic [HOLDOFF_BITS-1:0] holdoff_dec;
   logic [HOLDOFF_BITS-1:0] reload;
   logic [ANGLE_BITS-1:0]   diff;
   logic [ANGLE_BITS-1:0]   abs_diff;
   logic [ANGLE_BITS-1:0]   mag_ext;
   logic [1:0]              dir;
   logic [PROD_BITS-1:0]    product;
   logic [SPEED_BITS-1:0]   mag;
   logic                    qualified;
   logic                    blocked;
   logic                    overshoot;
   logic [ANGLE_BITS-1:0]   step_raw;

   // count the hold-off down, saturating at zero
   assign tick_ext    = HOLDOFF_BITS'(tick_length);
   assign holdoff_dec = (holdoff_left > tick_ext) ? (holdoff_left - tick_ext) : '0;
   assign reload      = HOLDOFF_BITS'(cfg.reversal_holdoff);

   // wrap the difference the short way round; half turn goes negative
   assign diff     = target_heading - current_heading;
   assign abs_diff = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
   assign dir      = (diff == '0) ? DIR_NONE : (diff[ANGLE_BITS-1] ? DIR_NEG : DIR_POS);

   // step magnitude from the Q16 product, truncated to whole angle units
   assign product = PROD_BITS'(cfg.slew_speed) * PROD_BITS'(tick_length);
   assign mag     = product[PROD_BITS-1:Q_FRAC_BITS];
   assign mag_ext = ANGLE_BITS'(mag);

   assign qualified = qual.present && !(cfg.only_when_moving && !qual.moving) && !qual.manual;
   assign blocked   = (dir != last_dir) && (holdoff_dec != '0);
   assign overshoot = (dir != DIR_NONE) && (CMP_BITS'(abs_diff) < CMP_BITS'(mag));

   // pick the step: clamp to the difference on overshoot
   always_comb begin
      if (overshoot) begin
         step_raw = diff;
      end else if (dir == DIR_POS) begin
         step_raw = mag_ext;
      end else if (dir == DIR_NEG) begin
         step_raw = ~mag_ext + 1'b1;
      end else begin
         step_raw = '0;
      end
   end

   // advance direction and hold-off
   always_comb begin
      last_dir_next = last_dir;
      holdoff_next  = holdoff_dec;
      step_applied  = 1'b0;
      heading_step  = '0;
      if (qualified && !blocked) begin
         step_applied = 1'b1;
         heading_step = step_raw;
         if (dir != last_dir) begin
            last_dir_next = dir;
            holdoff_next  = reload;
         end
         if (overshoot) begin
            last_dir_next = DIR_NONE;
            holdoff_next  = reload;
         end
      end
   end

endmodule

// ----- hw/rtl/heading_slew_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter unit
// Turns a view heading toward a target heading at a limited, held-off rate.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one tick per request: target and current heading (binary
//   angles), tick length in 2^-16 s and the present/moving/override flags.
//   rsp_if returns exactly one result per request, in order: the signed
//   heading step and a flag telling whether the tick computed a step.
//   csr_if writes slew_speed (0), reversal_holdoff (1), only_when_moving (2);
//   it is always ready. The user must write it only while no request is in
//   flight; the block itself has no check for this.
// Pipeline: a request passes the input register, then the result register;
//   one 16x16 multiply and a few compares sit between them.
// Throughput: one request per cycle while the receiver does not stall. Direction and hold-off state update as
//   each request moves into the result register, so the next tick sees it.
// Stall: while the receiver holds rsp_if.ready low the result register
//   holds, the input register fills, and req_if.ready then drops.
// Reset: clears both pipeline stages, direction and hold-off, and loads the
//   register reset values (slew_speed = 10 degrees per second).
// ----------------------------------------------------------------------------
module heading_slew_limiter_unit #(
   parameter int ANGLE_BITS   = 16,
   parameter int HOLDOFF_BITS = 20
) (
   input  logic      clock,
   input  logic      reset,
   hsl_req_if.sink   req_if,
   hsl_rsp_if.source rsp_if,
   hsl_csr_if.sink   csr_if
);
   import hsl_pkg::*;

   // configuration
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // input register
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [ANGLE_BITS-1:0] s1_target_ff;
   logic [ANGLE_BITS-1:0] s1_current_ff;
   logic [TICK_BITS-1:0]  s1_tick_ff;
   qual_type              s1_qual_ff;

   // result register
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic signed [ANGLE_BITS-1:0] out_step_ff;
   logic                         out_applied_ff;

   // state
   logic [1:0]              last_dir_ff;
   logic [1:0]              last_dir_in;
   logic [HOLDOFF_BITS-1:0] holdoff_ff;
   logic [HOLDOFF_BITS-1:0] holdoff_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         s1_advance;
   logic signed [ANGLE_BITS-1:0] core_step;
   logic                         core_applied;
   logic [1:0]                   core_dir;
   logic [HOLDOFF_BITS-1:0]      core_holdoff;

   // handshake
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign s1_advance    = s1_valid_ff && out_free;
   assign req_if.ready  = !s1_valid_ff || out_free;
   assign req_accept    = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.heading_step = out_step_ff;
   assign rsp_if.step_applied = out_applied_ff;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_SLEW_SPEED: begin
               cfg_in.slew_speed = csr_if.data[SPEED_BITS-1:0];
            end
            REG_REVERSAL_HOLDOFF: begin
               cfg_in.reversal_holdoff = csr_if.data[RELOAD_BITS-1:0];
            end
            REG_ONLY_WHEN_MOVING: begin
               cfg_in.only_when_moving = csr_if.data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_speed       <= SLEW_SPEED_RESET;
         cfg_ff.reversal_holdoff <= '0;
         cfg_ff.only_when_moving <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // step logic
   hsl_step_core #(
      .ANGLE_BITS   (ANGLE_BITS),
      .HOLDOFF_BITS (HOLDOFF_BITS)
   ) u_core (
      .cfg             (cfg_ff),
      .qual            (s1_qual_ff),
      .target_heading  (s1_target_ff),
      .current_heading (s1_current_ff),
      .tick_length     (s1_tick_ff),
      .last_dir        (last_dir_ff),
      .holdoff_left    (holdoff_ff),
      .heading_step    (core_step),
      .step_applied    (core_applied),
      .last_dir_next   (core_dir),
      .holdoff_next    (core_holdoff)
   );

   // pipeline control and state advance
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_if.ready);
   assign last_dir_in  = s1_advance ? core_dir : last_dir_ff;
   assign holdoff_in   = s1_advance ? core_holdoff : holdoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_dir_ff  <= DIR_NONE;
         holdoff_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         last_dir_ff  <= last_dir_in;
         holdoff_ff   <= holdoff_in;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_target_ff       <= req_if.target_heading;
         s1_current_ff      <= req_if.current_heading;
         s1_tick_ff         <= req_if.tick_length;
         s1_qual_ff.present <= req_if.target_present;
         s1_qual_ff.moving  <= req_if.target_moving;
         s1_qual_ff.manual  <= req_if.manual_override;
      end
   end

   // load the result
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_step_ff    <= core_step;
         out_applied_ff <= core_applied;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEXT(a_state_holds_without_advance, clock, reset, !s1_advance,
      $stable(last_dir_ff) && $stable(holdoff_ff), "state changed without a tick")
   `ASSERT_SAME(a_step_zero_when_not_applied, clock, reset,
      out_valid_ff && !out_applied_ff, out_step_ff == '0,
      "nonzero step on a tick that did not apply")
   `ASSERT_SAME(a_holdoff_never_grows, clock, reset, s1_advance,
      (holdoff_in <= holdoff_ff) || (holdoff_in == HOLDOFF_BITS'(cfg_ff.reversal_holdoff)),
      "hold-off grew other than by reload")
   `ASSERT_SAME(a_stall_means_full, clock, reset, !req_if.ready,
      s1_valid_ff && out_valid_ff && !rsp_if.ready, "request stalled with room free")

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Heading slew limiter testbench
// Drives ticks through the request channel under random idling, back
// pressure and several register settings. An in-bench predictor of the
// turn direction and hold-off timer checks every response in order.
// ----------------------------------------------------------------------------
module tb;
   import hsl_pkg::*;

   localparam int ANGLE_BITS   = 16;
   localparam int HOLDOFF_BITS = 20;

   // index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] target;
      logic [ANGLE_BITS-1:0] current;
      logic [TICK_BITS-1:0]  tick_len;
      qual_type              qual;
   } tick_req_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] step;
      logic                         applied;
   } step_result_type;

   // Predict heading steps and hold them until the matching response
   class slew_ledger;
      cfg_type                      cfg;
      logic [1:0]                   turn_dir;
      logic [HOLDOFF_BITS-1:0]      holdoff_left;
      logic signed [ANGLE_BITS-1:0] last_step;
      step_result_type              pending_steps[$];
      int                           mismatches;

      function new();
         cfg.slew_speed       = SLEW_SPEED_RESET;
         cfg.reversal_holdoff = '0;
         cfg.only_when_moving = 1'b0;
         turn_dir             = DIR_NONE;
         holdoff_left         = '0;
         last_step            = '0;
         mismatches           = 0;
      endfunction

      function void load_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_SLEW_SPEED: begin
               cfg.slew_speed = value[SPEED_BITS-1:0];
            end
            REG_REVERSAL_HOLDOFF: begin
               cfg.reversal_holdoff = value[RELOAD_BITS-1:0];
            end
            REG_ONLY_WHEN_MOVING: begin
               cfg.only_when_moving = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      // Work out the step for one accepted request and queue it
      function void note_tick(tick_req_type t);
         logic signed [ANGLE_BITS-1:0] diff;
         logic [1:0]                   turn;
         logic [HOLDOFF_BITS-1:0]      tick_ext;
         int                           d;
         int                           span;
         int                           mag;
         int                           step;
         step_result_type              want;
         want     = '0;
         tick_ext = HOLDOFF_BITS'(t.tick_len);
         // count down the hold-off, saturating at zero
         if (holdoff_left != '0)
            holdoff_left = (holdoff_left > tick_ext) ? holdoff_left - tick_ext : '0;
         if (t.qual.present && !(cfg.only_when_moving && !t.qual.moving) && !t.qual.manual) begin
            // wrap to the short way round; a half turn goes negative
            diff = t.target - t.current;
            d    = int'(diff);
            turn = (d > 0) ? DIR_POS : ((d < 0) ? DIR_NEG : DIR_NONE);
            // a direction change while the timer runs gives nothing
            if (turn == turn_dir || holdoff_left == '0) begin
               if (turn != turn_dir) begin
                  turn_dir     = turn;
                  holdoff_left = cfg.reversal_holdoff;
               end
               mag  = int'((longint'(cfg.slew_speed) * longint'(t.tick_len)) >> Q_FRAC_BITS);
               span = (d < 0) ? -d : d;
               step = (turn == DIR_POS) ? mag : ((turn == DIR_NEG) ? -mag : 0);
               // cut an overshoot to the remaining difference
               if (turn != DIR_NONE && span < mag) begin
                  turn_dir     = DIR_NONE;
                  holdoff_left = cfg.reversal_holdoff;
                  step         = d;
               end
               want.step    = step[ANGLE_BITS-1:0];
               want.applied = 1'b1;
            end
         end
         last_step = want.step;
         pending_steps.push_back(want);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: %s", msg);
      endfunction

      // Compare one response with the oldest prediction
      function void check_step(logic signed [ANGLE_BITS-1:0] step, logic applied);
         step_result_type want;
         if (pending_steps.size() == 0) begin
            flag($sformatf("unexpected response step %0d applied %0b", step, applied));
            return;
         end
         want = pending_steps.pop_front();
         if (step !== want.step)
            flag($sformatf("heading_step %0d, expected %0d", step, want.step));
         if (applied !== want.applied)
            flag($sformatf("step_applied %0b, expected %0b", applied, want.applied));
      endfunction

      function void flush_missing();
         step_result_type want;
         while (pending_steps.size() > 0) begin
            want = pending_steps.pop_front();
            flag($sformatf("missing response step %0d applied %0b", want.step, want.applied));
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   bit         calm = 1'b0;
   bit         long_hold_req = 1'b0;
   slew_ledger ledger;

   hsl_req_if #(.ANGLE_BITS(ANGLE_BITS)) req_if ();
   hsl_rsp_if #(.ANGLE_BITS(ANGLE_BITS)) rsp_if ();
   hsl_csr_if                            csr_if ();

   heading_slew_limiter_unit #(
      .ANGLE_BITS   (ANGLE_BITS),
      .HOLDOFF_BITS (HOLDOFF_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive response ready: random short stalls, plus one long hold on demand
   initial begin
      bit hold_seen;
      int hold_left;
      int gap_left;
      hold_seen    = 1'b0;
      hold_left    = 0;
      gap_left     = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req != hold_seen) begin
            hold_seen = long_hold_req;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_if.ready <= 1'b0;
            gap_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            gap_left = $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Check each response as it is accepted
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         ledger.check_step(rsp_if.heading_step, rsp_if.step_applied);
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic tick_req_type tick_of(logic [15:0] target, logic [15:0] current,
                                            logic [15:0] tick_len, logic present,
                                            logic moving, logic manual);
      tick_req_type t;
      t.target       = target;
      t.current      = current;
      t.tick_len     = tick_len;
      t.qual.present = present;
      t.qual.moving  = moving;
      t.qual.manual  = manual;
      return t;
   endfunction

   // Fill the bits above the register width with noise
   function automatic logic [CSR_DATA_BITS-1:0] pad_word(logic [CSR_DATA_BITS-1:0] value,
                                                         int width);
      logic [CSR_DATA_BITS-1:0] mask;
      mask = (width >= CSR_DATA_BITS) ? '1 : ((CSR_DATA_BITS'(1) << width) - 1);
      return (CSR_DATA_BITS'($urandom) & ~mask) | (value & mask);
   endfunction

   // Offer one request, with an occasional idle burst first
   task automatic send_tick(tick_req_type t);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.target_heading  <= t.target;
      req_if.current_heading <= t.current;
      req_if.tick_length     <= t.tick_len;
      req_if.target_present  <= t.qual.present;
      req_if.target_moving   <= t.qual.moving;
      req_if.manual_override <= t.qual.manual;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ledger.note_tick(t);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      ledger.load_reg(idx, value);
      @(negedge clock);
   endtask

   // Hold off new requests until every predicted step has come back
   task automatic settle_steps();
      req_if.valid <= 1'b0;
      while (ledger.pending_steps.size() > 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(logic [15:0] speed, logic [19:0] holdoff, logic owm);
      write_reg(REG_SLEW_SPEED, pad_word(CSR_DATA_BITS'(speed), SPEED_BITS));
      write_reg(REG_REVERSAL_HOLDOFF, pad_word(CSR_DATA_BITS'(holdoff), RELOAD_BITS));
      write_reg(REG_ONLY_WHEN_MOVING, pad_word(CSR_DATA_BITS'(owm), 1));
      csr_if.valid <= 1'b0;
   endtask

   // Random ticks: mostly a view that follows its own steps toward a target
   task automatic run_phase(int count, bit with_pressure);
      tick_req_type t;
      logic [15:0]  aim;
      logic [15:0]  view;
      logic [15:0]  delta;
      int           kind;
      bit           follow;
      aim  = 16'($urandom);
      view = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         // stall the receiver while requests keep coming, then pause the sender
         if (with_pressure && i == count / 2)
            long_hold_req = ~long_hold_req;
         if (with_pressure && i == count / 2 + 30)
            settle_steps();
         kind   = $urandom_range(0, 99);
         follow = kind >= 25;
         if (follow) begin
            if ($urandom_range(0, 9) == 0) begin
               delta = 16'($urandom_range(1, 4000));
               case ($urandom_range(0, 3))
                  0: aim = view + 16'h8000;
                  1: aim = 16'($urandom);
                  2: aim = view;
                  default: aim = $urandom_range(0, 1) ? view + delta : view - delta;
               endcase
            end
            t.target  = aim;
            t.current = view;
         end else begin
            t.current = 16'($urandom);
            case (kind % 5)
               0: t.target = t.current;
               1: t.target = t.current + 16'h8000;
               2: t.target = t.current + 16'h7FFF;
               3: t.target = t.current + 16'h8001;
               default: t.target = 16'($urandom);
            endcase
         end
         case ($urandom_range(0, 19))
            0: t.tick_len = '0;
            1: t.tick_len = '1;
            2, 3: t.tick_len = 16'($urandom);
            default: t.tick_len = 16'($urandom_range(1, 3000));
         endcase
         t.qual.present = $urandom_range(0, 11) != 0;
         t.qual.moving  = $urandom_range(0, 3) != 0;
         t.qual.manual  = $urandom_range(0, 11) == 0;
         send_tick(t);
         // advance the view by the step just predicted
         if (follow)
            view = view + ledger.last_step;
      end
   endtask

   initial begin
      ledger = new();
      req_if.valid           = 1'b0;
      req_if.target_heading  = '0;
      req_if.current_heading = '0;
      req_if.tick_length     = '0;
      req_if.target_present  = 1'b0;
      req_if.target_moving   = 1'b0;
      req_if.manual_override = 1'b0;
      csr_if.valid           = 1'b0;
      csr_if.index           = REG_SLEW_SPEED;
      csr_if.data            = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed ticks at reset settings: qualifiers, zero and half-turn differences
      send_tick(tick_of(16'd100, 16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0));
      send_tick(tick_of(16'd100, 16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1));
      send_tick(tick_of(16'hFFFF, 16'hFFFF, 16'd1000, 1'b1, 1'b0, 1'b0));
      send_tick(tick_of(16'h8000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'h7FFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'h0000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0));
      settle_steps();

      // Fastest turn, longest hold-off, movement required
      write_reg(REG_SPARE, $urandom);
      configure(16'hFFFF, 20'hFFFFF, 1'b1);
      send_tick(tick_of(16'd1000, 16'd0, 16'd100, 1'b1, 1'b0, 1'b0));
      send_tick(tick_of(16'd1000, 16'd0, 16'd100, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'd0, 16'd1000, 16'd100, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'd1000, 16'd950, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'd500, 16'd500, 16'd100, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'd0, 16'd1000, 16'd100, 1'b1, 1'b1, 1'b0));
      settle_steps();

      // Stopped turn rate
      configure(16'd0, 20'd0, 1'b0);
      send_tick(tick_of(16'h4000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0));
      send_tick(tick_of(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0));
      settle_steps();

      // Random phases over a spread of settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(SLEW_SPEED_RESET, 20'd0, 1'b0);
            1: configure(16'hFFFF, 20'hFFFFF, 1'b1);
            2: configure(16'd0, 20'd0, 1'b0);
            3: configure(16'($urandom_range(1, 8000)), 20'($urandom_range(1, 20000)), 1'b0);
            4: configure(16'hFFFF, 20'($urandom_range(0, 6000)), 1'b1);
            5: configure(16'($urandom), 20'($urandom), 1'($urandom_range(0, 1)));
            6: configure(16'($urandom_range(200, 3000)), 20'($urandom_range(100, 8000)),
                         1'b0);
            default: begin
               calm = 1'b1;
               configure(16'($urandom_range(1, 20000)), 20'($urandom_range(0, 5000)), 1'b1);
            end
         endcase
         run_phase(160, p == 6);
         settle_steps();
      end

      repeat (8) @(posedge clock);
      ledger.flush_missing();
      if (ledger.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
